### hw/rtl/lrc_pkg.sv
// Shared types, codes and interval helpers for the LRU region cache directory.
package lrc_pkg;

  localparam int FILL_W = 41;
  localparam int TAG_W = 448;

  localparam logic [2:0] OP_INSERT = 3'd0;
  localparam logic [2:0] OP_LOOKUP = 3'd1;
  localparam logic [2:0] OP_INVAL = 3'd2;
  localparam logic [2:0] OP_EVICT1 = 3'd3;
  localparam logic [2:0] OP_EVICTSZ = 3'd4;

  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_MISS = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;
  localparam logic [1:0] ST_EMPTY = 2'd3;

  typedef struct packed {
    logic [2:0]       opcode;
    logic [63:0]      object_id;
    logic [1:0]       dims;
    logic [2:0][63:0] start;
    logic [2:0][63:0] extent;
    logic [35:0]      byte_amount;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [9:0]  slot;
    logic [35:0] buffer_offset;
    logic [35:0] byte_count;
    logic        exact_match;
    logic [10:0] removed_count;
  } res_t;

  function automatic logic inside_f(logic [63:0] rs, logic [63:0] re,
                                    logic [63:0] es, logic [63:0] ee);
    logic [63:0] d;
    d = rs - es;
    return (rs >= es) && (d <= ee) && (re <= ee - d);
  endfunction

  function automatic logic overlap_f(logic [63:0] as, logic [63:0] ae,
                                     logic [63:0] bs, logic [63:0] be);
    logic r;
    if (as >= bs) r = ((as - bs) < be) && (ae != 64'd0);
    else r = ((bs - as) < ae) && (be != 64'd0);
    return r;
  endfunction

  function automatic logic [35:0] sat36(logic [35:0] a, logic [35:0] b);
    logic [36:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[36] ? 36'hF_FFFF_FFFF : s[35:0];
  endfunction

endpackage

### hw/rtl/lrc_ram.sv
// Generic single-write, single-read RAM with registered read data.
module lrc_ram #(
  parameter int W = 8,
  parameter int D = 16
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [$clog2(D)-1:0] waddr,
  input  logic [W-1:0]         wdata,
  input  logic                 re,
  input  logic [$clog2(D)-1:0] raddr,
  output logic [W-1:0]         rdata
);
  logic [W-1:0] mem [D];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (re) rdata <= mem[raddr];
  end
endmodule

### hw/rtl/lrc_front.sv
// Front end: accepts transactions, drops unknown opcodes, normalizes regions and queues the rest.
module lrc_front import lrc_pkg::*; #(
  parameter int MAX_DIMS = 3
) (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  req_t in_req,
  output logic req_valid,
  input  logic req_ready,
  output req_t req
);
  req_t q [2];
  logic wptr, rptr;
  logic [1:0] cnt;
  req_t norm;
  logic push, pop, keep;
  logic [1:0] nd;

  localparam logic [1:0] MaxD = 2'(MAX_DIMS);

  always_comb begin
    nd = in_req.dims;
    if (nd == 2'd0) nd = 2'd1;
    if (nd > MaxD) nd = MaxD;
    norm = in_req;
    norm.dims = nd;
    for (int d = 0; d < 3; d++) begin
      if (2'(d) >= nd) begin
        norm.start[d] = 64'd0;
        norm.extent[d] = 64'd0;
      end
    end
  end

  assign in_ready = (cnt != 2'd2);
  assign keep = (in_req.opcode <= OP_EVICTSZ);
  assign push = in_valid && in_ready && keep;
  assign req_valid = (cnt != 2'd0);
  assign req = q[rptr];
  assign pop = req_valid && req_ready;

  always_ff @(posedge clk) begin
    if (push) q[wptr] <= norm;
    if (rst) begin
      wptr <= 1'b0;
      rptr <= 1'b0;
      cnt <= 2'd0;
    end else begin
      if (push) wptr <= ~wptr;
      if (pop) rptr <= ~rptr;
      cnt <= cnt + 2'(push) - 2'(pop);
    end
  end

  assert property (@(posedge clk) disable iff (rst) cnt <= 2'd2)
    else $error("queue count out of range");
  assert property (@(posedge clk) disable iff (rst) (cnt == 2'd0) |-> (wptr == rptr))
    else $error("empty queue with mismatched pointers");
  assert property (@(posedge clk) disable iff (rst)
                   (push && !pop) |=> (cnt == $past(cnt) + 2'd1))
    else $error("queue count did not follow a push");
endmodule

### hw/rtl/lrc_back.sv
// Back end: recency list, free list and buffer pointer sequencer.
module lrc_back import lrc_pkg::*; #(
  parameter int SLOTS = 1024,
  parameter longint unsigned BUFFER_BYTES = 64'd34359738368
) (
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_ready,
  input  req_t req,
  output logic res_valid,
  input  logic res_ready,
  output res_t res
);
  localparam int LW = $clog2(SLOTS + 1);
  localparam int IW = $clog2(SLOTS);
  localparam logic [LW-1:0] NIL = LW'(SLOTS);
  localparam logic [FILL_W-1:0] BufC = BUFFER_BYTES[FILL_W-1:0];

  typedef enum logic [3:0] {
    S_CLR, S_IDLE, S_IRD, S_IWR, S_WRD, S_CMP, S_UL, S_LH1, S_LH2, S_RL, S_FIN
  } state_t;

  state_t state;
  req_t r;
  logic [LW-1:0] head, tail, free_head, cur, nx, guard, clr_i, removed, rslot;
  logic [FILL_W-1:0] fill;
  logic [46:0] freed;
  logic [35:0] total, boff, bcount;
  logic [1:0] status, dcnt;
  logic exact, mflag, sflag;

  logic [TAG_W-1:0] tag_rd;
  logic [FILL_W+35:0] loc_rd;
  logic [LW-1:0] next_rd, prev_rd;
  logic tag_we, nx_we, pv_we, rd_en;
  logic [IW-1:0] nx_wa, pv_wa, nx_ra;
  logic [LW-1:0] nx_wd, pv_wd;
  logic [TAG_W-1:0] tag_wd;

  logic [63:0] es, ee, rs, re;
  logic m_now, s_now, last_d;
  logic [35:0] len;
  logic [FILL_W:0] fsum;
  logic [LW-1:0] guard_inc;
  logic [LW+9:0] slot_ext;
  logic [LW+10:0] rm_ext;

  assign tag_wd = {r.extent, r.start, r.object_id};
  assign rd_en = (state == S_IRD) || (state == S_WRD);
  assign nx_ra = (state == S_IRD) ? free_head[IW-1:0] : cur[IW-1:0];
  assign tag_we = (state == S_IWR);

  always_comb begin
    nx_we = 1'b0; nx_wa = cur[IW-1:0]; nx_wd = NIL;
    pv_we = 1'b0; pv_wa = cur[IW-1:0]; pv_wd = NIL;
    unique case (state)
      S_CLR: begin
        nx_we = 1'b1; nx_wa = clr_i[IW-1:0]; nx_wd = clr_i + LW'(1);
        pv_we = 1'b1; pv_wa = clr_i[IW-1:0]; pv_wd = NIL;
      end
      S_UL: begin
        nx_we = (prev_rd < NIL); nx_wa = prev_rd[IW-1:0]; nx_wd = next_rd;
        pv_we = (next_rd < NIL); pv_wa = next_rd[IW-1:0]; pv_wd = prev_rd;
      end
      S_LH1: begin
        nx_we = 1'b1; nx_wd = head;
        pv_we = 1'b1; pv_wd = NIL;
      end
      S_LH2: begin
        pv_we = (head < NIL); pv_wa = head[IW-1:0]; pv_wd = cur;
      end
      S_RL: begin
        nx_we = 1'b1; nx_wd = free_head;
      end
      default: ;
    endcase
  end

  lrc_ram #(.W(TAG_W), .D(SLOTS)) u_tags (
    .clk(clk), .we(tag_we), .waddr(cur[IW-1:0]), .wdata(tag_wd),
    .re(rd_en), .raddr(cur[IW-1:0]), .rdata(tag_rd)
  );
  lrc_ram #(.W(FILL_W + 36), .D(SLOTS)) u_loc (
    .clk(clk), .we(tag_we), .waddr(cur[IW-1:0]), .wdata({fill, r.byte_amount}),
    .re(rd_en), .raddr(cur[IW-1:0]), .rdata(loc_rd)
  );
  lrc_ram #(.W(LW), .D(SLOTS)) u_next (
    .clk(clk), .we(nx_we), .waddr(nx_wa), .wdata(nx_wd),
    .re(rd_en), .raddr(nx_ra), .rdata(next_rd)
  );
  lrc_ram #(.W(LW), .D(SLOTS)) u_prev (
    .clk(clk), .we(pv_we), .waddr(pv_wa), .wdata(pv_wd),
    .re(rd_en), .raddr(cur[IW-1:0]), .rdata(prev_rd)
  );

  always_comb begin
    es = tag_rd[64 + 64 * dcnt +: 64];
    ee = tag_rd[256 + 64 * dcnt +: 64];
    rs = r.start[dcnt];
    re = r.extent[dcnt];
    m_now = ((dcnt == 2'd0) ? (tag_rd[63:0] == r.object_id) : mflag) &&
            ((r.opcode == OP_LOOKUP) ? inside_f(rs, re, es, ee) : overlap_f(rs, re, es, ee));
    s_now = ((dcnt == 2'd0) ? 1'b1 : sflag) && (rs == es) && (re == ee);
    last_d = (dcnt == r.dims - 2'd1);
    len = loc_rd[35:0];
    fsum = {1'b0, fill} + {(FILL_W - 35)'(0), req.byte_amount};
    guard_inc = guard + LW'(1);
    slot_ext = {10'd0, rslot};
    rm_ext = {11'd0, removed};
  end

  assign req_ready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLR;
      clr_i <= '0;
      head <= NIL;
      tail <= NIL;
      free_head <= '0;
      fill <= '0;
      guard <= '0;
      res_valid <= 1'b0;
    end else begin
      if (res_valid && res_ready && state != S_FIN) res_valid <= 1'b0;
      unique case (state)
        S_CLR: begin
          clr_i <= clr_i + LW'(1);
          if (clr_i == LW'(SLOTS - 1)) state <= S_IDLE;
        end
        S_IDLE: begin
          if (req_valid) begin
            r <= req;
            status <= ST_OK; rslot <= '0; boff <= '0; bcount <= '0;
            exact <= 1'b0; removed <= '0; total <= '0; freed <= '0;
            guard <= '0; dcnt <= '0;
            if (req.opcode == OP_INSERT) begin
              cur <= free_head;
              if (free_head >= NIL || fsum > {1'b0, BufC}) begin
                status <= ST_FULL; state <= S_FIN;
              end else state <= S_IRD;
            end else if (req.opcode == OP_LOOKUP) begin
              status <= ST_MISS; cur <= head;
              state <= (head < NIL) ? S_WRD : S_FIN;
            end else if (head >= NIL) begin
              status <= ST_EMPTY; state <= S_FIN;
            end else begin
              cur <= (req.opcode == OP_INVAL) ? head : tail;
              state <= S_WRD;
            end
          end
        end
        S_IRD: state <= S_IWR;
        S_IWR: begin
          free_head <= next_rd;
          fill <= fill + {(FILL_W - 36)'(0), r.byte_amount};
          rslot <= cur; boff <= fill[35:0]; bcount <= r.byte_amount;
          state <= S_LH1;
        end
        S_WRD: begin
          dcnt <= '0;
          state <= S_CMP;
        end
        S_CMP: begin
          if (r.opcode == OP_EVICT1 || r.opcode == OP_EVICTSZ) begin
            fill <= (fill > {(FILL_W - 36)'(0), len}) ?
                    fill - {(FILL_W - 36)'(0), len} : '0;
            freed <= freed + {11'd0, len};
            total <= sat36(total, len);
            rslot <= cur;
            boff <= loc_rd[71:36];
            removed <= removed + LW'(1);
            state <= S_UL;
          end else if (m_now && !last_d) begin
            mflag <= m_now; sflag <= s_now;
            dcnt <= dcnt + 2'd1;
          end else if (m_now) begin
            rslot <= cur; boff <= loc_rd[71:36];
            if (r.opcode == OP_LOOKUP) begin
              status <= ST_OK; exact <= s_now; bcount <= len;
            end else begin
              total <= sat36(total, len);
              removed <= removed + LW'(1);
            end
            state <= S_UL;
          end else begin
            guard <= guard_inc;
            cur <= next_rd;
            state <= (next_rd < NIL && guard_inc < LW'(SLOTS)) ? S_WRD : S_FIN;
          end
        end
        S_UL: begin
          nx <= next_rd;
          if (prev_rd >= NIL) head <= next_rd;
          if (next_rd >= NIL) tail <= prev_rd;
          state <= (r.opcode == OP_LOOKUP) ? S_LH1 : S_RL;
        end
        S_LH1: state <= S_LH2;
        S_LH2: begin
          if (head >= NIL) tail <= cur;
          head <= cur;
          state <= S_FIN;
        end
        S_RL: begin
          free_head <= cur;
          guard <= guard_inc;
          if (r.opcode == OP_INVAL) begin
            cur <= nx;
            state <= (nx < NIL && guard_inc < LW'(SLOTS)) ? S_WRD : S_FIN;
          end else if (r.opcode == OP_EVICT1 || freed >= {11'd0, r.byte_amount} ||
                       tail >= NIL || guard_inc >= LW'(SLOTS)) begin
            state <= S_FIN;
          end else begin
            cur <= tail;
            state <= S_WRD;
          end
        end
        S_FIN: begin
          if (!res_valid || res_ready) begin
            res_valid <= 1'b1;
            res.status <= status;
            res.slot <= slot_ext[9:0];
            res.buffer_offset <= boff;
            res.byte_count <= (r.opcode == OP_INVAL || r.opcode == OP_EVICT1 ||
                               r.opcode == OP_EVICTSZ) ? total : bcount;
            res.exact_match <= exact;
            res.removed_count <= rm_ext[10:0];
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assert property (@(posedge clk) disable iff (rst) (state == S_CLR) |-> !req_ready)
    else $error("request taken during clearing pass");
  assert property (@(posedge clk) disable iff (rst)
                   (state == S_IDLE) |-> ((head >= NIL) == (tail >= NIL)))
    else $error("head and tail disagree on empty list");
  assert property (@(posedge clk) disable iff (rst) guard <= LW'(SLOTS))
    else $error("walk guard overran slot count");
endmodule

### hw/rtl/lru_region_cache_directory.sv
// LRU region cache directory: top level with stream ports.
// Evict by size removes one entry after another from the tail. Lookup and invalidate walk
// the recency list from the head, up to SLOTS slots, with one tag read a slot and one compare
// a dimension; one transaction is handled at a time.
// Reset starts a clearing pass over all SLOTS slots; the input queue takes two transactions meanwhile.
module lru_region_cache_directory import lrc_pkg::*; #(
  parameter int SLOTS = 1024,
  parameter longint unsigned BUFFER_BYTES = 64'd34359738368,
  parameter int MAX_DIMS = 3
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // opcode, object_id, dims, start_d0..d2, extent_d0..d2, byte_amount, zero pad
  input  logic [495:0] s_tdata,
  output logic         m_tvalid,
  input  logic         m_tready,
  // status, slot, buffer_offset, byte_count, exact_match, removed_count
  output logic [95:0]  m_tdata
);
  req_t in_req, q_req;
  res_t res;
  logic q_valid, q_ready;

  assign in_req.opcode = s_tdata[2:0];
  assign in_req.object_id = s_tdata[66:3];
  assign in_req.dims = s_tdata[68:67];
  assign in_req.start[0] = s_tdata[132:69];
  assign in_req.start[1] = s_tdata[196:133];
  assign in_req.start[2] = s_tdata[260:197];
  assign in_req.extent[0] = s_tdata[324:261];
  assign in_req.extent[1] = s_tdata[388:325];
  assign in_req.extent[2] = s_tdata[452:389];
  assign in_req.byte_amount = s_tdata[488:453];

  lrc_front #(.MAX_DIMS(MAX_DIMS)) u_front (
    .clk(clk), .rst(rst), .in_valid(s_tvalid), .in_ready(s_tready), .in_req(in_req),
    .req_valid(q_valid), .req_ready(q_ready), .req(q_req)
  );

  lrc_back #(.SLOTS(SLOTS), .BUFFER_BYTES(BUFFER_BYTES)) u_back (
    .clk(clk), .rst(rst), .req_valid(q_valid), .req_ready(q_ready), .req(q_req),
    .res_valid(m_tvalid), .res_ready(m_tready), .res(res)
  );

  assign m_tdata = {res.removed_count, res.exact_match, res.byte_count,
                    res.buffer_offset, res.slot, res.status};
endmodule

### sim/tb_top.sv
// Self-checking stream testbench for the LRU region cache directory.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import lrc_pkg::*;

  localparam int NSLOT = 1024;
  localparam longint unsigned BUF_BYTES = 64'd34359738368;
  localparam longint unsigned MASK36 = 64'hF_FFFF_FFFF;

  typedef struct packed {
    logic [2:0]       op;
    logic [63:0]      obj;
    logic [1:0]       dims;
    logic [2:0][63:0] st;
    logic [2:0][63:0] ex;
    logic [35:0]      amount;
  } dir_req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [9:0]  slot;
    logic [35:0] boff;
    logic [35:0] bcount;
    logic        exact;
    logic [10:0] removed;
  } dir_res_t;

  class dir_scoreboard;
    logic [63:0] tag_obj[NSLOT];
    logic [2:0][63:0] tag_st[NSLOT];
    logic [2:0][63:0] tag_ex[NSLOT];
    longint unsigned loc_off[NSLOT];
    longint unsigned loc_len[NSLOT];
    int prv[NSLOT];
    int nxt[NSLOT];
    int head, tail, free_h, cnt;
    longint unsigned fill;
    dir_res_t due_q[$];
    int errors;

    function new();
      for (int i = 0; i < NSLOT; i++) begin
        prv[i] = NSLOT;
        nxt[i] = i + 1;
      end
      head = NSLOT;
      tail = NSLOT;
      free_h = 0;
      cnt = 0;
      fill = 0;
      errors = 0;
    endfunction

    function void unlink(int s);
      int p, n;
      p = prv[s];
      n = nxt[s];
      if (p < NSLOT) nxt[p] = n; else head = n;
      if (n < NSLOT) prv[n] = p; else tail = p;
    endfunction

    function void link_head(int s);
      nxt[s] = head;
      prv[s] = NSLOT;
      if (head < NSLOT) prv[head] = s; else tail = s;
      head = s;
    endfunction

    function void release_slot(int s);
      unlink(s);
      nxt[s] = free_h;
      free_h = s;
      if (cnt > 0) cnt--;
    endfunction

    function bit contains(logic [63:0] rs, logic [63:0] re, logic [63:0] es,
                          logic [63:0] ee);
      logic [63:0] d;
      if (rs < es) return 0;
      d = rs - es;
      if (d > ee) return 0;
      return re <= ee - d;
    endfunction

    function bit overlap(logic [63:0] as, logic [63:0] ae, logic [63:0] bs,
                         logic [63:0] be);
      if (as >= bs) return ((as - bs) < be) && (ae != 64'd0);
      return ((bs - as) < ae) && (be != 64'd0);
    endfunction

    function longint unsigned sat(longint unsigned a, longint unsigned b);
      longint unsigned t;
      t = a + b;
      return t > MASK36 ? MASK36 : t;
    endfunction

    function void note(dir_req_t it);
      dir_res_t r;
      int unsigned nd;
      logic [2:0][63:0] st, ex;
      int s, g, nx;
      bit hit, same;
      longint unsigned amt, total, freed, len;
      if (it.op > OP_EVICTSZ) return;
      r = '0;
      total = 0;
      freed = 0;
      amt = 64'(it.amount);
      nd = (it.dims == 2'd0) ? 1 : 32'(it.dims);
      for (int d = 0; d < 3; d++) begin
        st[d] = d < nd ? it.st[d] : 64'd0;
        ex[d] = d < nd ? it.ex[d] : 64'd0;
      end
      if (it.op == OP_INSERT) begin
        s = free_h;
        if (s >= NSLOT || amt > BUF_BYTES || fill > BUF_BYTES - amt) begin
          r.status = ST_FULL;
        end else begin
          free_h = nxt[s];
          tag_obj[s] = it.obj;
          tag_st[s] = st;
          tag_ex[s] = ex;
          loc_off[s] = fill;
          loc_len[s] = amt;
          fill += amt;
          link_head(s);
          cnt++;
          r.slot = 10'(s);
          r.boff = 36'(loc_off[s]);
          r.bcount = 36'(amt);
        end
      end else if (it.op == OP_LOOKUP) begin
        r.status = ST_MISS;
        s = head;
        for (g = 0; s < NSLOT && g < NSLOT; g++) begin
          hit = tag_obj[s] == it.obj;
          same = 1;
          for (int d = 0; d < nd && hit; d++) begin
            hit = contains(st[d], ex[d], tag_st[s][d], tag_ex[s][d]);
            if (st[d] != tag_st[s][d] || ex[d] != tag_ex[s][d]) same = 0;
          end
          if (hit) begin
            r.status = ST_OK;
            r.slot = 10'(s);
            r.exact = same;
            r.boff = 36'(loc_off[s]);
            r.bcount = 36'(loc_len[s]);
            unlink(s);
            link_head(s);
            break;
          end
          s = nxt[s];
        end
      end else if (head >= NSLOT) begin
        r.status = ST_EMPTY;
      end else if (it.op == OP_INVAL) begin
        s = head;
        for (g = 0; s < NSLOT && g < NSLOT; g++) begin
          nx = nxt[s];
          hit = tag_obj[s] == it.obj;
          for (int d = 0; d < nd && hit; d++)
            hit = overlap(st[d], ex[d], tag_st[s][d], tag_ex[s][d]);
          if (hit) begin
            total = sat(total, loc_len[s]);
            r.slot = 10'(s);
            r.boff = 36'(loc_off[s]);
            release_slot(s);
            r.removed++;
          end
          s = nx;
        end
        r.bcount = 36'(total);
      end else begin
        for (g = 0; tail < NSLOT && g < NSLOT; g++) begin
          s = tail;
          len = loc_len[s];
          fill = fill > len ? fill - len : 0;
          freed += len;
          total = sat(total, len);
          r.slot = 10'(s);
          r.boff = 36'(loc_off[s]);
          release_slot(s);
          r.removed++;
          if (it.op == OP_EVICT1 || freed >= amt) break;
        end
        r.bcount = 36'(total);
      end
      due_q.push_back(r);
    endfunction

    task report(string field, logic [63:0] got, logic [63:0] want);
      $display("mismatch in %s: got %0h expected %0h", field, got, want);
      errors++;
    endtask

    task check(logic [95:0] data);
      dir_res_t w;
      if (due_q.size() == 0) begin
        report("unexpected result", data[63:0], 64'd0);
        return;
      end
      w = due_q.pop_front();
      if (data[1:0] != w.status) report("status", 64'(data[1:0]), 64'(w.status));
      if (data[11:2] != w.slot) report("slot", 64'(data[11:2]), 64'(w.slot));
      if (data[47:12] != w.boff)
        report("buffer_offset", 64'(data[47:12]), 64'(w.boff));
      if (data[83:48] != w.bcount)
        report("byte_count", 64'(data[83:48]), 64'(w.bcount));
      if (data[84] != w.exact) report("exact_match", 64'(data[84]), 64'(w.exact));
      if (data[95:85] != w.removed)
        report("removed_count", 64'(data[95:85]), 64'(w.removed));
    endtask
  endclass

  logic clk = 1'b0;
  logic rst;
  logic s_tvalid;
  logic s_tready;
  logic [495:0] s_tdata;
  logic m_tvalid;
  logic m_tready;
  logic [95:0] m_tdata;

  dir_scoreboard sb;
  int burst_left = 0;
  int cyc = 0;
  int hold_left = 0;
  bit hold_req = 0;
  bit hold_used = 0;
  logic [63:0] obj_pool[4];
  dir_req_t recent_q[$];

  lru_region_cache_directory i_dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    cyc++;
    if (hold_req && !hold_used) begin
      hold_used = 1;
      hold_left = 400;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_tready <= 1'b0;
    end else begin
      case ((cyc / 150) % 3)
        0: m_tready <= 1'b1;
        1: m_tready <= ($urandom_range(0, 3) != 0);
        default: m_tready <= (cyc % 3 != 0);
      endcase
    end
  end

  always @(posedge clk) begin
    if (!rst && sb != null && m_tvalid && m_tready) sb.check(m_tdata);
  end

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic dir_req_t mk(logic [2:0] op, logic [63:0] obj, logic [1:0] dims,
                                  logic [63:0] s0, logic [63:0] e0, logic [63:0] s1,
                                  logic [63:0] e1, logic [63:0] s2, logic [63:0] e2,
                                  logic [35:0] amount);
    dir_req_t it;
    it.op = op;
    it.obj = obj;
    it.dims = dims;
    it.st = {s2, s1, s0};
    it.ex = {e2, e1, e0};
    it.amount = amount;
    return it;
  endfunction

  task offer(dir_req_t it);
    int g;
    if (burst_left == 0) begin
      g = $urandom_range(0, 6);
      if (g > 0) begin
        s_tvalid <= 1'b0;
        repeat (g) @(posedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    s_tdata <= {7'd0, it.amount, it.ex, it.st, it.dims, it.obj, it.op};
    s_tvalid <= 1'b1;
    do @(posedge clk); while (!s_tready);
    sb.note(it);
  endtask

  task drain();
    s_tvalid <= 1'b0;
    burst_left = 0;
    do @(posedge clk); while (sb.due_q.size() > 0);
  endtask

  function automatic dir_req_t rand_req();
    dir_req_t it, h;
    int r;
    logic [63:0] k;
    r = $urandom_range(0, 99);
    if (sb.cnt > 24 && r < 65) r = 80 + $urandom_range(0, 14);
    if (r < 35) it.op = OP_INSERT;
    else if (r < 65) it.op = OP_LOOKUP;
    else if (r < 77) it.op = OP_INVAL;
    else if (r < 85) it.op = OP_EVICT1;
    else if (r < 95) it.op = OP_EVICTSZ;
    else it.op = 3'($urandom_range(5, 7));
    it.obj = ($urandom_range(0, 9) != 0) ? obj_pool[$urandom_range(0, 3)] : rand64();
    it.dims = 2'($urandom_range(0, 3));
    for (int d = 0; d < 3; d++) begin
      if ($urandom_range(0, 9) == 0) begin
        it.st[d] = rand64();
        it.ex[d] = rand64();
      end else begin
        it.st[d] = 64'($urandom_range(0, 31));
        it.ex[d] = 64'($urandom_range(0, 16));
      end
    end
    if (it.op != OP_INSERT && recent_q.size() > 0 && $urandom_range(0, 9) < 7) begin
      h = recent_q[$urandom_range(0, recent_q.size() - 1)];
      it.obj = h.obj;
      it.dims = h.dims;
      it.st = h.st;
      it.ex = h.ex;
      if ($urandom_range(0, 1)) begin
        for (int d = 0; d < 3; d++) begin
          k = (it.ex[d] > 64'd2) ? 64'($urandom_range(0, 2)) : 64'd0;
          it.st[d] = it.st[d] + k;
          it.ex[d] = it.ex[d] - k - ((it.ex[d] > k) ? 64'($urandom_range(0, 1)) : 64'd0);
        end
      end
    end
    r = $urandom_range(0, 19);
    if (it.op == OP_INSERT)
      it.amount = (r < 2) ? 36'({$urandom, $urandom})
                : (r == 2) ? 36'd0 : 36'($urandom_range(0, 4096));
    else
      it.amount = (r == 0) ? 36'({$urandom, $urandom}) : 36'($urandom_range(0, 8192));
    return it;
  endfunction

  initial begin
    dir_req_t it;
    logic [63:0] oa, ob, top;
    int done_items;
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    m_tready = 1'b0;
    sb = new();
    for (int i = 0; i < 4; i++) obj_pool[i] = rand64();
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    oa = 64'h0123_4567_89AB_CDEF;
    ob = ~oa;
    top = '1;
    offer(mk(OP_EVICT1, oa, 1, 0, 0, 0, 0, 0, 0, 0));
    offer(mk(OP_INVAL, oa, 1, 0, 10, 0, 0, 0, 0, 0));
    offer(mk(OP_EVICTSZ, oa, 1, 0, 0, 0, 0, 0, 0, 100));
    offer(mk(OP_LOOKUP, oa, 1, 0, 1, 0, 0, 0, 0, 0));
    offer(mk(OP_INSERT, oa, 0, 10, 5, 7, 7, 7, 7, 100));
    offer(mk(OP_INSERT, ob, 3, top, top, top, top, top, top, 36'hF_FFFF_FFFF));
    offer(mk(OP_INSERT, ob, 3, top, top, top, top, top, top, 36'h8));
    offer(mk(OP_LOOKUP, ob, 3, top, top, top, top, top, top, 0));
    offer(mk(OP_LOOKUP, oa, 1, 10, 5, 0, 0, 0, 0, 0));
    offer(mk(OP_LOOKUP, oa, 2, 11, 3, 0, 0, 0, 0, 0));
    offer(mk(OP_LOOKUP, oa, 1, 15, 0, 0, 0, 0, 0, 0));
    offer(mk(OP_LOOKUP, oa, 1, 12, 9, 0, 0, 0, 0, 0));
    offer(mk(OP_INVAL, oa, 1, 0, 0, 0, 0, 0, 0, 0));
    offer(mk(3'd5, oa, 1, 0, 0, 0, 0, 0, 0, 0));
    offer(mk(3'd6, oa, 1, 0, 0, 0, 0, 0, 0, 0));
    offer(mk(3'd7, oa, 1, 0, 0, 0, 0, 0, 0, 0));
    offer(mk(OP_INSERT, oa, 2, 0, 4, 0, 4, 0, 0, 36'd50));
    offer(mk(OP_INVAL, oa, 2, 3, 1, 2, 9, 0, 0, 0));
    offer(mk(OP_EVICTSZ, ob, 1, 0, 0, 0, 0, 0, 0, 5));
    offer(mk(OP_EVICT1, ob, 1, 0, 0, 0, 0, 0, 0, 0));
    drain();
    offer(mk(OP_INSERT, oa, 1, 0, 8, 0, 0, 0, 0, 36'(BUF_BYTES - sb.fill)));
    offer(mk(OP_INSERT, oa, 1, 0, 8, 0, 0, 0, 0, 36'd0));
    offer(mk(OP_INSERT, oa, 1, 0, 8, 0, 0, 0, 0, 36'd1));
    offer(mk(OP_EVICTSZ, oa, 1, 0, 0, 0, 0, 0, 0, 36'hF_FFFF_FFFF));
    drain();
    offer(mk(OP_LOOKUP, ob, 1, 0, 1, 0, 0, 0, 0, 0));
    offer(mk(OP_EVICTSZ, oa, 1, 0, 0, 0, 0, 0, 0, 36'd1));
    drain();

    done_items = 0;
    while (done_items < 267) begin
      if (done_items == 100) hold_req = 1;
      if (done_items == 180) drain();
      it = rand_req();
      offer(it);
      if (it.op <= OP_EVICTSZ) done_items++;
      if (it.op == OP_INSERT) begin
        recent_q.push_back(it);
        if (recent_q.size() > 16) void'(recent_q.pop_front());
      end
    end
    drain();
    repeat (6000) @(posedge clk);
    if (sb.errors == 0) $display("PASS lru_region_cache_directory");
    else $display("FAIL lru_region_cache_directory");
    $finish;
  end

  initial begin
    #20000000;
    $display("FAIL lru_region_cache_directory");
    $finish;
  end
endmodule

### files.f
hw/rtl/lrc_pkg.sv
hw/rtl/lrc_ram.sv
hw/rtl/lrc_front.sv
hw/rtl/lrc_back.sv
hw/rtl/lru_region_cache_directory.sv
sim/tb_top.sv
